/* rtl/rau_pkg.sv */
// rau_pkg: opcodes, status codes, queue entry and back-end state types.
// No dependencies; used by every module of the rational arithmetic unit.
`default_nettype none
package rau_pkg;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_NEG  = 3'd4,
        OP_NORM = 3'd5,
        OP_EQ   = 3'd6,
        OP_RSV  = 3'd7
    } op_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_ZDEN = 2'd2;

    // Classified word handed from front to back.
    typedef struct packed {
        op_t         op;
        logic        uses_b;
        logic        zden;
        logic [63:0] an;
        logic [63:0] ad;
        logic [63:0] bn;
        logic [63:0] bd;
    } job_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RED_START,
        S_GCD,
        S_DIVN,
        S_DIVD,
        S_RED_FIN,
        S_OP1,
        S_OP2,
        S_OP3,
        S_OUT
    } bstate_t;

endpackage
`default_nettype wire

/* rtl/rau_front.sv */
// rau_front: accepts input words, masks operands to WIDTH bits and flags
// zero denominators and unused operands. Depends on rau_pkg.
`default_nettype none
module rau_front #(
    parameter int WIDTH = 64
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [2:0]    s_op,
    input  wire logic [63:0]   s_a_num,
    input  wire logic [63:0]   s_a_den,
    input  wire logic [63:0]   s_b_num,
    input  wire logic [63:0]   s_b_den,
    output logic               q_valid,
    input  wire logic          q_ready,
    output rau_pkg::job_t      q_job
);
    import rau_pkg::*;

    localparam logic [63:0] WMASK = {64{1'b1}} >> (64 - WIDTH);

    job_t job_reg, job_next;
    logic vld_reg;
    logic [63:0] an, ad, bn, bd;
    logic ub;

    assign an = s_a_num & WMASK;
    assign ad = s_a_den & WMASK;
    assign bn = s_b_num & WMASK;
    assign bd = s_b_den & WMASK;
    assign ub = (s_op <= 3'(OP_DIV)) || (s_op == 3'(OP_EQ));

    // single-entry register stage: accepts when empty or draining
    assign s_ready = !vld_reg || q_ready;

    always_comb begin
        job_next.op     = op_t'(s_op);
        job_next.uses_b = ub;
        job_next.zden   = (ad == '0) || (ub && bd == '0);
        job_next.an     = an;
        job_next.ad     = ad;
        job_next.bn     = bn;
        job_next.bd     = bd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (s_ready) begin
            vld_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            job_reg <= job_next;
        end
    end

    assign q_valid = vld_reg;
    assign q_job   = job_reg;
endmodule
`default_nettype wire

/* rtl/rau_fifo.sv */
// rau_fifo: two-entry queue of classified words between front and back.
// Depends on rau_pkg.
`default_nettype none
module rau_fifo (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  rau_pkg::job_t   in_job,
    output logic            out_valid,
    input  wire logic       out_ready,
    output rau_pkg::job_t   out_job
);
    import rau_pkg::*;

    job_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic push, pop;

    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_job   = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= !wp_reg;
            if (pop)  rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
        if (push) mem_reg[wp_reg] <= in_job;
    end
endmodule
`default_nettype wire

/* rtl/rau_back.sv */
// rau_back: sequencer that reduces operands, applies the operation and
// reduces the result, with bit-serial divide and multiply units. Uses rau_pkg.
`default_nettype none
module rau_back #(
    parameter int WIDTH = 64
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          q_valid,
    output logic               q_ready,
    input  rau_pkg::job_t      q_job,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [63:0]        m_res_num,
    output logic [62:0]        m_res_den,
    output logic               m_is_equal,
    output logic [1:0]         m_status
);
    import rau_pkg::*;

    localparam int CW = $clog2(WIDTH + 1);
    localparam logic [WIDTH-1:0] WSIGN = {1'b1, {(WIDTH-1){1'b0}}};

    typedef logic [WIDTH-1:0] w_t;

    bstate_t st_reg, st_next;
    op_t op_reg;
    logic [1:0] phase_reg;   // 0 reduce a, 1 reduce b, 2 reduce result
    w_t an_reg, ad_reg, bn_reg, bd_reg;
    w_t x_reg, y_reg;        // fraction being reduced
    w_t g_reg, h_reg;        // gcd pair
    w_t nm_reg;              // reduced numerator magnitude
    w_t t1_reg, t2_reg;      // product staging
    logic ovf_reg, eq_reg, ub_reg, zd_reg;
    // shift-subtract divider, also paces the multiplier
    w_t dq_reg, dr_reg, dv_reg;
    logic [CW-1:0] dc_reg;
    logic dbusy_reg;
    logic [WIDTH:0] rtrial;
    w_t rsh;
    // shift-add multiplier on magnitudes
    logic [2*WIDTH-1:0] mp_reg;
    w_t mca_reg;
    logic mneg_reg;
    logic [1:0] mi_reg;      // which product of the op is running
    logic [WIDTH:0] mp_sum;
    w_t mul_a, mul_b, mul_wr;
    logic mul_ovf, has_mul;
    logic [1:0] mul_last;

    logic mvld_reg;
    logic [63:0] onum_reg;
    logic [62:0] oden_reg;
    logic oeq_reg;
    logic [1:0] ost_reg;

    function automatic logic neg_bit(input w_t v);
        return v[WIDTH-1];
    endfunction

    function automatic w_t mag(input w_t v);
        return v[WIDTH-1] ? w_t'(-v) : v;
    endfunction

    assign rtrial = {dr_reg, dq_reg[WIDTH-1]};
    assign rsh = rtrial[WIDTH-1:0];

    // product order: add/sub an*bd, bn*ad, ad*bd; mul an*bn, ad*bd; div an*bd, ad*bn
    always_comb begin
        mul_a = an_reg;
        mul_b = bd_reg;
        case (mi_reg)
            2'd0: begin
                mul_a = an_reg;
                mul_b = (op_reg == OP_MUL) ? bn_reg : bd_reg;
            end
            2'd1: begin
                mul_a = (op_reg inside {OP_ADD, OP_SUB}) ? bn_reg : ad_reg;
                if (op_reg == OP_MUL)      mul_b = bd_reg;
                else if (op_reg == OP_DIV) mul_b = bn_reg;
                else                       mul_b = ad_reg;
            end
            default: begin
                mul_a = ad_reg;
                mul_b = bd_reg;
            end
        endcase
    end

    assign has_mul  = op_reg inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV};
    assign mul_last = (op_reg inside {OP_ADD, OP_SUB}) ? 2'd2 : 2'd1;
    assign mp_sum   = {1'b0, mp_reg[2*WIDTH-1:WIDTH]} + (mp_reg[0] ? {1'b0, mca_reg} : '0);
    assign mul_wr   = mneg_reg ? w_t'(-mp_reg[WIDTH-1:0]) : mp_reg[WIDTH-1:0];
    assign mul_ovf  = mneg_reg ? (mp_reg > {{WIDTH{1'b0}}, WSIGN})
                               : (mp_reg > {{WIDTH{1'b0}}, WSIGN - 1'b1});

    assign q_ready = (st_reg == S_IDLE);

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            S_IDLE:      if (q_valid) st_next = S_RED_START;
            S_RED_START: st_next = (y_reg == '0) ? S_OUT : S_GCD;
            S_GCD:       if (!dbusy_reg && h_reg == '0) st_next = S_DIVN;
            S_DIVN:      if (dbusy_reg && dc_reg == '0) st_next = S_DIVD;
            S_DIVD:      if (dbusy_reg && dc_reg == '0) st_next = S_RED_FIN;
            S_RED_FIN: begin
                if (phase_reg == 2'd0 && ub_reg) st_next = S_RED_START;
                else if (phase_reg == 2'd2)      st_next = S_OUT;
                else if (has_mul)                st_next = S_OP1;
                else                             st_next = S_OP2;
            end
            S_OP1: begin
                if (dbusy_reg && dc_reg == '0 && mi_reg == mul_last) st_next = S_OP2;
            end
            S_OP2:       st_next = S_OP3;
            S_OP3:       st_next = S_RED_START;
            S_OUT:       if (!m_valid || m_ready) st_next = S_IDLE;
            default:     st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= S_IDLE;
            dbusy_reg <= 1'b0;
            mvld_reg  <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (st_reg == S_OUT && (!mvld_reg || m_ready)) begin
                mvld_reg <= 1'b1;
            end else if (mvld_reg && m_ready) begin
                mvld_reg <= 1'b0;
            end
            case (st_reg)
                S_IDLE: begin
                    dbusy_reg <= 1'b0;
                    mi_reg    <= 2'd0;
                end
                S_GCD: begin
                    if (!dbusy_reg) begin
                        if (h_reg != '0) begin
                            dbusy_reg <= 1'b1;
                            dq_reg <= g_reg; dr_reg <= '0; dv_reg <= h_reg;
                            dc_reg <= CW'(WIDTH);
                        end
                    end else if (dc_reg == '0) begin
                        dbusy_reg <= 1'b0;
                        g_reg <= h_reg;
                        h_reg <= dr_reg;
                    end else begin
                        dc_reg <= dc_reg - 1'b1;
                        dq_reg <= {dq_reg[WIDTH-2:0], ~(rtrial < {1'b0, dv_reg})};
                        dr_reg <= (rtrial < {1'b0, dv_reg}) ? rsh : w_t'(rtrial - {1'b0, dv_reg});
                    end
                end
                S_DIVN, S_DIVD: begin
                    if (!dbusy_reg) begin
                        dbusy_reg <= 1'b1;
                        dq_reg <= (st_reg == S_DIVN) ? mag(x_reg) : mag(y_reg);
                        dr_reg <= '0; dv_reg <= g_reg;
                        dc_reg <= CW'(WIDTH);
                    end else if (dc_reg == '0) begin
                        dbusy_reg <= 1'b0;
                        if (st_reg == S_DIVN) nm_reg <= dq_reg;
                    end else begin
                        dc_reg <= dc_reg - 1'b1;
                        dq_reg <= {dq_reg[WIDTH-2:0], ~(rtrial < {1'b0, dv_reg})};
                        dr_reg <= (rtrial < {1'b0, dv_reg}) ? rsh : w_t'(rtrial - {1'b0, dv_reg});
                    end
                end
                S_OP1: begin
                    // one product bit per cycle
                    if (!dbusy_reg) begin
                        dbusy_reg <= 1'b1;
                        mp_reg    <= {{WIDTH{1'b0}}, mag(mul_b)};
                        mca_reg   <= mag(mul_a);
                        mneg_reg  <= neg_bit(mul_a) != neg_bit(mul_b);
                        dc_reg    <= CW'(WIDTH);
                    end else if (dc_reg == '0) begin
                        dbusy_reg <= 1'b0;
                        mi_reg    <= mi_reg + 2'd1;
                    end else begin
                        dc_reg <= dc_reg - 1'b1;
                        mp_reg <= {mp_sum, mp_reg[WIDTH-1:1]};
                    end
                end
                default: ;
            endcase
        end

        // datapath without reset
        case (st_reg)
            S_IDLE: begin
                op_reg    <= q_job.op;
                ub_reg    <= q_job.uses_b;
                zd_reg    <= q_job.zden;
                an_reg    <= w_t'(q_job.an);
                ad_reg    <= w_t'(q_job.ad);
                bn_reg    <= w_t'(q_job.bn);
                bd_reg    <= w_t'(q_job.bd);
                x_reg     <= w_t'(q_job.an);
                y_reg     <= w_t'(q_job.ad);
                phase_reg <= 2'd0;
                ovf_reg   <= 1'b0;
                eq_reg    <= 1'b0;
            end
            S_RED_START: begin
                g_reg <= mag(x_reg);
                h_reg <= mag(y_reg);
                if (y_reg == '0) zd_reg <= 1'b1;
            end
            S_RED_FIN: begin : fin
                logic negr;
                w_t xr, yr;
                negr = (neg_bit(x_reg) != neg_bit(y_reg)) && nm_reg != '0;
                xr = negr ? w_t'(-nm_reg) : nm_reg;
                yr = dq_reg;
                if ((!negr && nm_reg == WSIGN) || dq_reg == WSIGN) ovf_reg <= 1'b1;
                if (phase_reg == 2'd0) begin
                    an_reg <= xr; ad_reg <= yr;
                    x_reg <= bn_reg; y_reg <= bd_reg;
                    phase_reg <= ub_reg ? 2'd1 : 2'd2;
                    t1_reg <= xr; t2_reg <= yr;
                end else if (phase_reg == 2'd1) begin
                    bn_reg <= xr; bd_reg <= yr;
                    phase_reg <= 2'd2;
                end else begin
                    x_reg <= xr; y_reg <= yr;
                end
            end
            S_OP1: begin
                // finished product: first two staged, third is the add/sub denominator
                if (dbusy_reg && dc_reg == '0) begin
                    case (mi_reg)
                        2'd0:    t1_reg <= mul_wr;
                        2'd1:    t2_reg <= mul_wr;
                        default: y_reg  <= mul_wr;
                    endcase
                    if (mul_ovf) ovf_reg <= 1'b1;
                end
            end
            S_OP2: begin
                // final products for mul/div, unary ops and compare
                case (op_reg)
                    OP_ADD, OP_SUB: ;
                    OP_MUL, OP_DIV: begin
                        x_reg <= t1_reg; y_reg <= t2_reg;
                    end
                    OP_NEG: begin
                        x_reg <= w_t'(-an_reg); y_reg <= ad_reg;
                        if (an_reg == WSIGN) ovf_reg <= 1'b1;
                    end
                    OP_EQ: begin
                        eq_reg <= (an_reg == bn_reg) && (ad_reg == bd_reg);
                        x_reg <= an_reg; y_reg <= ad_reg;
                    end
                    default: begin
                        x_reg <= an_reg; y_reg <= ad_reg;
                    end
                endcase
            end
            S_OP3: begin : op3
                w_t s;
                if (op_reg == OP_ADD) begin
                    s = t1_reg + t2_reg;
                    x_reg <= s;
                    if (neg_bit(t1_reg) == neg_bit(t2_reg) && neg_bit(s) != neg_bit(t1_reg))
                        ovf_reg <= 1'b1;
                end else if (op_reg == OP_SUB) begin
                    s = t1_reg - t2_reg;
                    x_reg <= s;
                    if (neg_bit(t1_reg) != neg_bit(t2_reg) && neg_bit(s) != neg_bit(t1_reg))
                        ovf_reg <= 1'b1;
                end
            end
            S_OUT: begin
                if (!mvld_reg || m_ready) begin
                    if (zd_reg) begin
                        onum_reg <= '0; oden_reg <= '0;
                        oeq_reg <= 1'b0; ost_reg <= ST_ZDEN;
                    end else begin
                        onum_reg <= 64'(signed'(x_reg));
                        oden_reg <= 63'(y_reg);
                        oeq_reg  <= eq_reg;
                        ost_reg  <= ovf_reg ? ST_OVF : ST_OK;
                    end
                end
            end
            default: ;
        endcase
    end

    assign m_valid    = mvld_reg;
    assign m_res_num  = onum_reg;
    assign m_res_den  = oden_reg;
    assign m_is_equal = oeq_reg;
    assign m_status   = ost_reg;
endmodule
`default_nettype wire

/* rtl/rational_arithmetic_unit.sv */
// rational_arithmetic_unit: top level of the fraction arithmetic block.
// Instantiates rau_front, rau_fifo and rau_back; uses rau_pkg.
//
//   channel  dir  handshake           payload
//   s_       in   s_valid / s_ready   s_op, s_a_num, s_a_den, s_b_num, s_b_den
//   m_       out  m_valid / m_ready   m_res_num, m_res_den, m_is_equal, m_status
//
// Sequence: each word is reduced up to three times; a reduction runs k gcd
// remainder steps plus two divisions, all on the shared serial divider.
// Add/sub take three serial products, mul/div two. The time taken per word
// is set by the gcd step count.
// Reset: aresetn synchronous, active low; clears queue and sequencer.
// Stalls: the front and two-entry queue keep accepting while the back works
// until both are full; the result register holds until m_ready.
`default_nettype none
module rational_arithmetic_unit #(
    parameter int WIDTH = 64
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [2:0]   s_op,
    input  wire logic [63:0]  s_a_num,
    input  wire logic [63:0]  s_a_den,
    input  wire logic [63:0]  s_b_num,
    input  wire logic [63:0]  s_b_den,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [63:0]       m_res_num,
    output logic [62:0]       m_res_den,
    output logic              m_is_equal,
    output logic [1:0]        m_status
);
    import rau_pkg::*;

    job_t f_job, b_job;
    logic f_valid, f_ready, b_valid, b_ready;

    rau_front #(.WIDTH(WIDTH)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_op, .s_a_num, .s_a_den,
        .s_b_num, .s_b_den,
        .q_valid(f_valid), .q_ready(f_ready), .q_job(f_job)
    );

    rau_fifo u_fifo (
        .aclk, .aresetn,
        .in_valid(f_valid), .in_ready(f_ready), .in_job(f_job),
        .out_valid(b_valid), .out_ready(b_ready), .out_job(b_job)
    );

    rau_back #(.WIDTH(WIDTH)) u_back (
        .aclk, .aresetn,
        .q_valid(b_valid), .q_ready(b_ready), .q_job(b_job),
        .m_valid, .m_ready, .m_res_num, .m_res_den, .m_is_equal, .m_status
    );
endmodule
`default_nettype wire
